// ===== design/iat_pkg.sv =====
// Shared types, codes and helpers for the interval allocation tracker.
// Used by iat_ctrl, iat_dp and interval_allocation_tracker; no dependencies.
package iat_pkg;

    localparam int unsigned ADDR_W     = 16;
    localparam int unsigned LEN_W      = 16;
    localparam int unsigned COST_W     = 48;
    localparam int unsigned ENTRY_W    = ADDR_W + LEN_W;
    localparam int unsigned IN_DATA_W  = 48;
    localparam int unsigned OUT_DATA_W = 72;
    localparam int unsigned INC_W      = 20;
    localparam int unsigned COST_ALLOC = 10;
    localparam int unsigned COST_FREE  = 5;
    localparam int unsigned COST_MOVE  = 15;

    typedef enum logic [2:0] {
        ST_OK, ST_OVERLAP, ST_BOUND, ST_NOT_ALLOC,
        ST_SRC_BOUND, ST_DST_BOUND, ST_SAME, ST_FULL
    } status_t;

    typedef enum logic [1:0] {FN_ALLOC, FN_FREE, FN_MOVE, FN_CLEAR} func_t;

    typedef enum logic [1:0] {WK_NONE, WK_SCAN, WK_REMOVE, WK_INSERT} walk_t;

    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_AL_SCAN, S_AL_CHECK, S_FIND, S_MV_CHECK,
        S_MV_SCAN, S_REMOVE, S_INSERT, S_COST, S_ACC, S_FINISH
    } state_t;

    typedef struct packed {
        logic    load;
        logic    walk;
        logic    walk_rst;
        walk_t   mode;
        logic    set_status;
        status_t status;
        logic    take_idx;
        logic    take_pos;
        logic    pos_count;
        logic    take_mpos;
        logic    mpos_end;
        logic    dec_count;
        logic    ins_fin;
        logic    calc;
        logic    acc;
        logic    clear;
        logic    emit;
    } iat_cmd_t;

    typedef struct packed {
        func_t func;
        logic  ent;
        logic  alloc_hit;
        logic  alloc_ovl;
        logic  find_hit;
        logic  mv_hit;
        logic  mv_ovl;
        logic  walk_done;
        logic  bound;
        logic  same;
        logic  src_bound;
        logic  dst_bound;
        logic  full;
        logic  out_busy;
    } iat_stat_t;

    function automatic logic [12:0] chunks(input logic [16:0] n);
        logic [17:0] t;
        t = 18'(n) + 18'd31;
        return t[17:5];
    endfunction

endpackage

// ===== design/iat_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module iat_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;
endmodule

// ===== design/iat_ctrl.sv =====
// Sequencer of the interval allocation tracker: one state machine that walks
// each operation through the scan, remove, insert and cost steps it needs. Uses iat_pkg.
module iat_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  iat_pkg::iat_stat_t stat,
    output iat_pkg::iat_cmd_t  cmd
);
    import iat_pkg::*;

    state_t state_reg, state_next;

    function automatic walk_t walk_of(input state_t s);
        walk_t w;
        unique case (s)
            S_AL_SCAN, S_FIND, S_MV_SCAN: w = WK_SCAN;
            S_REMOVE:                     w = WK_REMOVE;
            S_INSERT:                     w = WK_INSERT;
            default:                      w = WK_NONE;
        endcase
        return w;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) state_next = S_DISPATCH;
            end
            S_DISPATCH: begin
                unique case (stat.func)
                    FN_ALLOC: state_next = stat.bound ? S_FINISH : S_AL_SCAN;
                    FN_FREE:  state_next = S_FIND;
                    FN_MOVE:  state_next = (stat.same || stat.src_bound) ? S_FINISH : S_FIND;
                    default:  state_next = S_FINISH;
                endcase
            end
            S_AL_SCAN: begin
                if (stat.ent && stat.alloc_hit) begin
                    state_next = stat.alloc_ovl ? S_FINISH : S_AL_CHECK;
                end else if (stat.walk_done) begin
                    state_next = S_AL_CHECK;
                end
            end
            S_AL_CHECK: state_next = stat.full ? S_FINISH : S_INSERT;
            S_FIND: begin
                if (stat.ent && stat.find_hit) begin
                    state_next = (stat.func == FN_FREE) ? S_REMOVE : S_MV_CHECK;
                end else if (stat.walk_done) begin
                    state_next = S_FINISH;
                end
            end
            S_MV_CHECK: state_next = stat.dst_bound ? S_FINISH : S_MV_SCAN;
            S_MV_SCAN: begin
                if (stat.ent && stat.mv_hit) begin
                    state_next = stat.mv_ovl ? S_FINISH : S_REMOVE;
                end else if (stat.walk_done) begin
                    state_next = S_REMOVE;
                end
            end
            S_REMOVE: begin
                if (stat.walk_done) state_next = (stat.func == FN_FREE) ? S_COST : S_INSERT;
            end
            S_INSERT: begin
                if (stat.walk_done) state_next = S_COST;
            end
            S_COST: state_next = S_ACC;
            S_ACC:  state_next = S_FINISH;
            S_FINISH: begin
                if (!stat.out_busy) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd          = '0;
        cmd.status   = ST_OK;
        s_tready     = (state_reg == S_IDLE);
        cmd.walk     = (walk_of(state_reg) != WK_NONE);
        cmd.walk_rst = (state_next != state_reg) && (walk_of(state_next) != WK_NONE);
        cmd.mode     = walk_of(state_next);
        unique case (state_reg)
            S_IDLE: cmd.load = s_tvalid;
            S_DISPATCH: begin
                unique case (stat.func)
                    FN_ALLOC: begin
                        cmd.set_status = stat.bound;
                        cmd.status     = ST_BOUND;
                    end
                    FN_FREE: ;
                    FN_MOVE: begin
                        cmd.set_status = stat.same || stat.src_bound;
                        cmd.status     = stat.same ? ST_SAME : ST_SRC_BOUND;
                    end
                    default: begin
                        cmd.clear      = 1'b1;
                        cmd.set_status = 1'b1;
                        cmd.status     = ST_OK;
                    end
                endcase
            end
            S_AL_SCAN: begin
                if (stat.ent && stat.alloc_hit) begin
                    cmd.set_status = stat.alloc_ovl;
                    cmd.status     = ST_OVERLAP;
                    cmd.take_pos   = !stat.alloc_ovl;
                end else if (stat.walk_done) begin
                    cmd.pos_count = 1'b1;
                end
            end
            S_AL_CHECK: begin
                cmd.set_status = stat.full;
                cmd.status     = ST_FULL;
            end
            S_FIND: begin
                if (stat.ent && stat.find_hit) begin
                    cmd.take_idx = 1'b1;
                end else if (stat.walk_done) begin
                    cmd.set_status = 1'b1;
                    cmd.status     = ST_NOT_ALLOC;
                end
            end
            S_MV_CHECK: begin
                cmd.set_status = stat.dst_bound;
                cmd.status     = ST_DST_BOUND;
            end
            S_MV_SCAN: begin
                if (stat.ent && stat.mv_hit) begin
                    cmd.set_status = stat.mv_ovl;
                    cmd.status     = ST_OVERLAP;
                    cmd.take_mpos  = !stat.mv_ovl;
                end else if (stat.walk_done) begin
                    cmd.mpos_end = 1'b1;
                end
            end
            S_REMOVE: cmd.dec_count = stat.walk_done;
            S_INSERT: cmd.ins_fin = stat.walk_done;
            S_COST:   cmd.calc = 1'b1;
            S_ACC: begin
                cmd.acc        = 1'b1;
                cmd.set_status = 1'b1;
                cmd.status     = ST_OK;
            end
            S_FINISH: cmd.emit = !stat.out_busy;
            default: ;
        endcase
    end

`ifndef SYNTH
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> (cmd.walk == 1'b0))
        else $error("input taken while a table walk runs");
    a_emit_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |=> (state_reg == S_IDLE))
        else $error("result sent outside the finish step");
    a_load_dispatch: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> (state_reg == S_DISPATCH))
        else $error("accepted item not dispatched");
`endif
endmodule

// ===== design/iat_dp.sv =====
// Datapath of the interval allocation tracker: region table RAM, walk index,
// totals and result register. Uses iat_pkg and iat_ram.
module iat_dp #(
    parameter logic [32:0] MEM_CAP     = 33'd65536,
    parameter int unsigned MAX_REGIONS = 64
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [iat_pkg::IN_DATA_W-1:0]     s_tdata,
    input  logic [1:0]                        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [iat_pkg::OUT_DATA_W-1:0]    m_tdata,
    input  iat_pkg::iat_cmd_t                 cmd,
    output iat_pkg::iat_stat_t                stat
);
    import iat_pkg::*;

    localparam int unsigned AW = $clog2(MAX_REGIONS);
    localparam int unsigned CW = $clog2(MAX_REGIONS + 1);

    func_t             func_reg;
    logic [15:0]       addr_reg, size_reg, dst_reg, len_reg;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     k_reg, k_next, q_idx_reg, q_idx_next, idx_reg, pos_reg;
    logic              q_valid_reg, q_valid_next;
    walk_t             mode_reg;
    status_t           status_reg;
    logic [COST_W-1:0] cost_reg, cost_next;
    logic [15:0]       bytes_reg, bytes_next;
    logic [INC_W-1:0]  inc_reg;
    logic              m_valid_reg;
    logic [OUT_DATA_W-1:0] m_data_reg;

    logic [ENTRY_W-1:0] rd_data, wr_data;
    logic [AW-1:0]      rd_addr, wr_addr;
    logic [CW-1:0]      rd_full, wr_full;
    logic               wr_en, more;
    logic [15:0]        ent_start, ent_len;
    logic [16:0]        ent_end, al_end, mv_end, src_end, mv_dist;
    logic [COST_W:0]    sum;
    logic [INC_W-1:0]   inc_next;

    iat_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_REGIONS)) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign ent_start = rd_data[15:0];
    assign ent_len   = rd_data[31:16];
    assign ent_end   = 17'(ent_start) + 17'(ent_len);
    assign al_end    = 17'(addr_reg) + 17'(size_reg);
    assign mv_end    = 17'(dst_reg) + 17'(len_reg);
    assign src_end   = 17'(addr_reg) + 17'(len_reg);
    assign more      = (mode_reg == WK_INSERT) ? (k_reg > pos_reg) : (k_reg < count_reg);

    always_comb begin
        stat           = '0;
        stat.func      = func_reg;
        stat.ent       = q_valid_reg;
        stat.alloc_hit = ent_end > 17'(addr_reg);
        stat.alloc_ovl = 17'(ent_start) < al_end;
        stat.find_hit  = ent_start == addr_reg;
        stat.mv_hit    = (q_idx_reg != idx_reg) && (17'(dst_reg) < ent_end);
        stat.mv_ovl    = !(mv_end <= 17'(ent_start));
        stat.walk_done = !q_valid_reg && !more;
        stat.bound     = 33'(al_end) >= MEM_CAP;
        stat.same      = addr_reg == dst_reg;
        stat.src_bound = 33'(addr_reg) >= MEM_CAP;
        stat.dst_bound = 33'(mv_end) >= MEM_CAP;
        stat.full      = count_reg >= CW'(MAX_REGIONS);
        stat.out_busy  = m_valid_reg && !m_tready;
    end

    always_comb begin
        k_next       = k_reg;
        q_valid_next = q_valid_reg;
        q_idx_next   = q_idx_reg;
        if (cmd.walk_rst) begin
            q_valid_next = 1'b0;
            unique case (cmd.mode)
                WK_SCAN:   k_next = '0;
                WK_REMOVE: k_next = (cmd.take_idx ? q_idx_reg : idx_reg) + CW'(1);
                WK_INSERT: k_next = cmd.dec_count ? count_reg - CW'(1) : count_reg;
                default:   k_next = k_reg;
            endcase
        end else if (cmd.walk) begin
            q_valid_next = more;
            if (more) begin
                q_idx_next = k_reg;
                k_next     = (mode_reg == WK_INSERT) ? k_reg - CW'(1) : k_reg + CW'(1);
            end
        end
    end

    always_comb begin
        rd_full = (mode_reg == WK_INSERT) ? k_reg - CW'(1) : k_reg;
        rd_addr = rd_full[AW-1:0];
        wr_en   = 1'b0;
        wr_full = pos_reg;
        wr_data = (func_reg == FN_ALLOC) ? {size_reg, addr_reg} : {len_reg, dst_reg};
        if (cmd.ins_fin) begin
            wr_en = 1'b1;
        end else if (cmd.walk && !cmd.walk_rst && q_valid_reg) begin
            if (mode_reg == WK_REMOVE) begin
                wr_en   = 1'b1;
                wr_full = q_idx_reg - CW'(1);
                wr_data = rd_data;
            end else if (mode_reg == WK_INSERT) begin
                wr_en   = 1'b1;
                wr_full = q_idx_reg;
                wr_data = rd_data;
            end
        end
        wr_addr = wr_full[AW-1:0];
    end

    always_comb begin
        if ((17'(addr_reg) >= mv_end) || (src_end <= 17'(dst_reg))) begin
            mv_dist = 17'(len_reg);
        end else if (dst_reg > addr_reg) begin
            mv_dist = 17'(dst_reg) - 17'(addr_reg);
        end else begin
            mv_dist = 17'(len_reg) + (17'(addr_reg) - 17'(dst_reg));
        end
        case (func_reg)
            FN_ALLOC: inc_next = INC_W'(chunks(17'(size_reg))) * INC_W'(COST_ALLOC);
            FN_FREE:  inc_next = INC_W'(chunks(17'(len_reg))) * INC_W'(COST_FREE);
            FN_MOVE:  inc_next = INC_W'(chunks(mv_dist)) * INC_W'(COST_MOVE)
                               + INC_W'(chunks(17'(len_reg))) * INC_W'(COST_ALLOC);
            default:  inc_next = '0;
        endcase
    end

    always_comb begin
        sum        = {1'b0, cost_reg} + (COST_W + 1)'(inc_reg);
        count_next = count_reg;
        cost_next  = cost_reg;
        bytes_next = bytes_reg;
        if (cmd.clear) begin
            count_next = '0;
            cost_next  = '0;
            bytes_next = '0;
        end else begin
            if (cmd.ins_fin) count_next = count_reg + CW'(1);
            if (cmd.dec_count) count_next = count_reg - CW'(1);
            if (cmd.acc) begin
                cost_next = sum[COST_W] ? {COST_W{1'b1}} : sum[COST_W-1:0];
                if (func_reg == FN_ALLOC) bytes_next = bytes_reg + size_reg;
                else if (func_reg == FN_FREE) bytes_next = bytes_reg - len_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            cost_reg    <= '0;
            bytes_reg   <= '0;
            k_reg       <= '0;
            q_valid_reg <= 1'b0;
            mode_reg    <= WK_NONE;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            cost_reg    <= cost_next;
            bytes_reg   <= bytes_next;
            k_reg       <= k_next;
            q_valid_reg <= q_valid_next;
            if (cmd.walk_rst) mode_reg <= cmd.mode;
            if (cmd.emit) m_valid_reg <= 1'b1;
            else if (m_tready) m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        q_idx_reg <= q_idx_next;
        if (cmd.load) begin
            func_reg <= func_t'(s_tuser);
            addr_reg <= s_tdata[15:0];
            size_reg <= s_tdata[31:16];
            dst_reg  <= s_tdata[47:32];
        end
        if (cmd.set_status) status_reg <= cmd.status;
        if (cmd.take_idx) begin
            idx_reg <= q_idx_reg;
            len_reg <= ent_len;
        end
        if (cmd.take_pos) pos_reg <= q_idx_reg;
        if (cmd.pos_count) pos_reg <= count_reg;
        if (cmd.take_mpos) pos_reg <= (q_idx_reg > idx_reg) ? q_idx_reg - CW'(1) : q_idx_reg;
        if (cmd.mpos_end) pos_reg <= count_reg - CW'(1);
        if (cmd.calc) inc_reg <= inc_next;
        if (cmd.emit) m_data_reg <= {5'b0, bytes_reg, cost_reg, status_reg};
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(MAX_REGIONS))
        else $error("region count past capacity");
    a_insert_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.ins_fin |-> (count_reg < CW'(MAX_REGIONS)))
        else $error("insert into full table");
    a_cost_mono: assert property (@(posedge aclk) disable iff (!aresetn)
        !cmd.clear |=> (cost_reg >= $past(cost_reg)))
        else $error("cost total went down without clear");
`endif
endmodule

// ===== design/interval_allocation_tracker.sv =====
// Interval allocation tracker: one operation per transfer. The single read and
// write port of the region table RAM sets the pace, one entry per cycle for each
// scan, remove shift and insert shift. One result per transfer, held in an output
// register. Synchronous active-low reset clears counts, totals and handshakes;
// table contents stay undefined, with no clearing pass. Uses iat_pkg, iat_ctrl,
// iat_dp.
module interval_allocation_tracker #(
    parameter logic [32:0] MEM_CAP     = 33'd65536,
    parameter int unsigned MAX_REGIONS = 64
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [iat_pkg::IN_DATA_W-1:0]  s_tdata,  // addr, size, dst_addr
    input  logic [1:0]                     s_tuser,  // func
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [iat_pkg::OUT_DATA_W-1:0] m_tdata   // status, cost_total, bytes_in_use
);
    import iat_pkg::*;

    iat_cmd_t  cmd;
    iat_stat_t stat;

    iat_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    iat_dp #(.MEM_CAP(MEM_CAP), .MAX_REGIONS(MAX_REGIONS)) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .stat     (stat)
    );
endmodule
